// ===== hw/rtl/ffa_pkg.sv =====
`timescale 1ns / 1ps

package ffa_pkg;

    localparam int BINS       = 1024;
    localparam int LEVELS     = (BINS <= 2) ? 1 : $clog2(BINS);
    localparam int LEAVES     = 2 ** LEVELS;
    localparam int NODES      = 2 * LEAVES;
    localparam int NODE_W     = LEVELS + 1;
    localparam int BIN_W      = 10;
    localparam int AMOUNT_W   = 32;
    localparam int VALUE_W    = AMOUNT_W + 1;
    localparam int QUEUE_DEPTH = 2;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_PLACE = 1'b1;

    typedef struct packed {
        logic                kind;
        logic [BIN_W-1:0]    bin_index;
        logic [AMOUNT_W-1:0] amount;
    } in_item_t;

    typedef struct packed {
        logic                placed;
        logic [BIN_W-1:0]    placed_index;
        logic [AMOUNT_W-1:0] unplaced_count;
    } out_item_t;

    typedef enum logic [1:0] {
        OP_DROP,
        OP_LOAD,
        OP_PLACE
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t             op;
        logic [NODE_W-1:0]   node;
        logic [VALUE_W-1:0]  value;
    } cmd_t;

    typedef struct packed {
        logic clearing;
    } back_status_t;

    typedef struct packed {
        logic full;
        logic valid;
    } queue_status_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ROOT,
        ST_DOWN,
        ST_UP
    } back_state_t;

endpackage

// ===== hw/rtl/ffa_front.sv =====
`timescale 1ns / 1ps

module ffa_front (
    input  logic                   start,
    input  ffa_pkg::in_item_t      command,
    input  ffa_pkg::back_status_t  back_status,
    input  ffa_pkg::queue_status_t queue_status,
    output logic                   busy,
    output logic                   push,
    output ffa_pkg::cmd_t          cmd
);

    assign busy = back_status.clearing || queue_status.full;
    assign push = start && !busy;

    always_comb
    begin
        cmd.node  = ffa_pkg::NODE_W'(ffa_pkg::LEAVES) + ffa_pkg::NODE_W'(command.bin_index);
        cmd.value = ffa_pkg::VALUE_W'(command.amount) + ffa_pkg::VALUE_W'(1);
        if (command.kind == ffa_pkg::KIND_PLACE)
        begin
            cmd.op = ffa_pkg::OP_PLACE;
        end
        else if (32'(command.bin_index) < 32'(ffa_pkg::BINS))
        begin
            cmd.op = ffa_pkg::OP_LOAD;
        end
        else
        begin
            cmd.op = ffa_pkg::OP_DROP;
        end
    end

endmodule

// ===== hw/rtl/ffa_queue.sv =====
`timescale 1ns / 1ps

module ffa_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  ffa_pkg::cmd_t          push_cmd,
    input  logic                   pop,
    output ffa_pkg::cmd_t          head_cmd,
    output ffa_pkg::queue_status_t status
);

    localparam int PTR_W = $clog2(ffa_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(ffa_pkg::QUEUE_DEPTH + 1);

    ffa_pkg::cmd_t          entry_reg [ffa_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]       wr_ptr_reg;
    logic [PTR_W-1:0]       wr_ptr_next;
    logic [PTR_W-1:0]       rd_ptr_reg;
    logic [PTR_W-1:0]       rd_ptr_next;
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;
    logic                   do_pop;

    assign do_pop       = pop && (count_reg != '0);
    assign head_cmd     = entry_reg[rd_ptr_reg];
    assign status.valid = (count_reg != '0);
    assign status.full  = (count_reg == CNT_W'(ffa_pkg::QUEUE_DEPTH));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(ffa_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                           : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(ffa_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                           : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== hw/rtl/ffa_back.sv =====
`timescale 1ns / 1ps

module ffa_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  ffa_pkg::queue_status_t queue_status,
    input  ffa_pkg::cmd_t          head_cmd,
    output logic                   pop,
    output ffa_pkg::back_status_t  status,
    output ffa_pkg::out_item_t     result,
    output logic                   result_valid
);

    localparam int NW = ffa_pkg::NODE_W;
    localparam int VW = ffa_pkg::VALUE_W;
    localparam int AW = ffa_pkg::AMOUNT_W;

    logic [VW-1:0]          tree_mem [ffa_pkg::NODES];
    logic [VW-1:0]          rdata_reg;
    logic                   mem_we;
    logic [NW-1:0]          waddr;
    logic [VW-1:0]          wdata;
    logic [NW-1:0]          raddr;

    ffa_pkg::back_state_t   state_reg;
    ffa_pkg::back_state_t   state_next;
    logic [NW-1:0]          node_reg;
    logic [NW-1:0]          node_next;
    logic [VW-1:0]          value_reg;
    logic [VW-1:0]          value_next;
    logic [VW-1:0]          need_reg;
    logic [VW-1:0]          need_next;
    logic [AW-1:0]          miss_reg;
    logic [AW-1:0]          miss_next;
    ffa_pkg::out_item_t     result_reg;
    ffa_pkg::out_item_t     result_next;
    logic                   result_valid_reg;
    logic                   result_valid_next;

    logic [NW-1:0]          child;
    logic [NW-1:0]          parent;
    logic [VW-1:0]          parent_value;

    assign child        = {node_reg[NW-2:0], ~(rdata_reg >= need_reg)};
    assign parent       = node_reg >> 1;
    assign parent_value = (rdata_reg > value_reg) ? rdata_reg : value_reg;

    assign status.clearing = (state_reg == ffa_pkg::ST_CLEAR);
    assign result          = result_reg;
    assign result_valid    = result_valid_reg;

    always_comb
    begin
        state_next        = state_reg;
        node_next         = node_reg;
        value_next        = value_reg;
        need_next         = need_reg;
        miss_next         = miss_reg;
        result_next       = result_reg;
        result_valid_next = 1'b0;
        pop               = 1'b0;
        mem_we            = 1'b0;
        waddr             = node_reg;
        wdata             = '0;
        raddr             = '0;

        unique case (state_reg)
            ffa_pkg::ST_CLEAR:
            begin
                mem_we    = 1'b1;
                waddr     = node_reg;
                wdata     = '0;
                node_next = node_reg + 1'b1;
                if (node_reg == NW'(ffa_pkg::NODES - 1))
                begin
                    state_next = ffa_pkg::ST_IDLE;
                end
            end
            ffa_pkg::ST_IDLE:
            begin
                if (queue_status.valid)
                begin
                    pop = 1'b1;
                    unique case (head_cmd.op)
                        ffa_pkg::OP_LOAD:
                        begin
                            mem_we     = 1'b1;
                            waddr      = head_cmd.node;
                            wdata      = head_cmd.value;
                            raddr      = head_cmd.node ^ NW'(1);
                            node_next  = head_cmd.node;
                            value_next = head_cmd.value;
                            state_next = ffa_pkg::ST_UP;
                        end
                        ffa_pkg::OP_PLACE:
                        begin
                            raddr      = NW'(1);
                            need_next  = head_cmd.value;
                            state_next = ffa_pkg::ST_ROOT;
                        end
                        default:
                        begin
                            state_next = ffa_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            ffa_pkg::ST_ROOT:
            begin
                if (rdata_reg >= need_reg)
                begin
                    raddr      = NW'(2);
                    node_next  = NW'(1);
                    state_next = ffa_pkg::ST_DOWN;
                end
                else
                begin
                    if (miss_reg != '1)
                    begin
                        miss_next = miss_reg + 1'b1;
                    end
                    result_next.placed         = 1'b0;
                    result_next.placed_index   = '0;
                    result_next.unplaced_count = (miss_reg != '1) ? miss_reg + 1'b1 : miss_reg;
                    result_valid_next          = 1'b1;
                    state_next                 = ffa_pkg::ST_IDLE;
                end
            end
            ffa_pkg::ST_DOWN:
            begin
                node_next = child;
                if (child[NW-1])
                begin
                    mem_we                     = 1'b1;
                    waddr                      = child;
                    wdata                      = '0;
                    raddr                      = child ^ NW'(1);
                    value_next                 = '0;
                    result_next.placed         = 1'b1;
                    result_next.placed_index   = ffa_pkg::BIN_W'(child[NW-2:0]);
                    result_next.unplaced_count = miss_reg;
                    result_valid_next          = 1'b1;
                    state_next                 = ffa_pkg::ST_UP;
                end
                else
                begin
                    raddr = {child[NW-2:0], 1'b0};
                end
            end
            ffa_pkg::ST_UP:
            begin
                mem_we     = 1'b1;
                waddr      = parent;
                wdata      = parent_value;
                node_next  = parent;
                value_next = parent_value;
                if (parent == NW'(1))
                begin
                    state_next = ffa_pkg::ST_IDLE;
                end
                else
                begin
                    raddr = parent ^ NW'(1);
                end
            end
            default:
            begin
                state_next = ffa_pkg::ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ffa_pkg::ST_CLEAR;
            node_reg         <= '0;
            miss_reg         <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            node_reg         <= node_next;
            miss_reg         <= miss_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg  <= value_next;
        need_reg   <= need_next;
        result_reg <= result_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            tree_mem[waddr] <= wdata;
        end
        rdata_reg <= tree_mem[raddr];
    end

endmodule

// ===== hw/rtl/first_fit_max_tree_allocator_top.sv =====
`timescale 1ns / 1ps

// After reset the block sweeps its 2048-node tree memory to zero, one node per cycle, and
// holds busy high throughout that sweep. An item is taken when start is high and busy is
// low; a two-entry queue sits in front of the tree engine, so after the sweep busy rises
// only when that queue is full. In the engine a load item takes one leaf write and ten
// steps up the path, a miss takes only the root read, and a request that is
// placed takes the root read, ten steps down and ten back up, one tree level per cycle
// through the single read and single write port of the tree memory. Each request gives one
// result, shown for exactly one cycle with result_valid, and the receiver cannot stall it.

module first_fit_max_tree_allocator_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  ffa_pkg::in_item_t  command,
    output ffa_pkg::out_item_t result,
    output logic               result_valid
);

    ffa_pkg::cmd_t          push_cmd;
    ffa_pkg::cmd_t          head_cmd;
    ffa_pkg::queue_status_t queue_status;
    ffa_pkg::back_status_t  back_status;
    logic                   push;
    logic                   pop;

    ffa_front u_front (
        .start        (start),
        .command      (command),
        .back_status  (back_status),
        .queue_status (queue_status),
        .busy         (busy),
        .push         (push),
        .cmd          (push_cmd)
    );

    ffa_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .status   (queue_status)
    );

    ffa_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .queue_status (queue_status),
        .head_cmd     (head_cmd),
        .pop          (pop),
        .status       (back_status),
        .result       (result),
        .result_valid (result_valid)
    );

endmodule

// ===== hw/rtl/ffa_checker.sv =====
`timescale 1ns / 1ps

module ffa_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               busy,
    input ffa_pkg::out_item_t result,
    input logic               result_valid
);

    // Two results never come in consecutive cycles.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
    else $error("results on consecutive cycles");

    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.placed) |-> (result.placed_index == '0))
    else $error("unplaced result carries a bin index");

    // A miss always counts itself.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.placed) |-> (result.unplaced_count != '0))
    else $error("miss reported with zero unplaced count");

    // The first cycle after reset belongs to the clearing sweep.
    assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> busy)
    else $error("block not busy right after reset");

endmodule

bind first_fit_max_tree_allocator_top ffa_checker u_ffa_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .busy         (busy),
    .result       (result),
    .result_valid (result_valid)
);
